@@ design/ashd_pkg.sv @@
// Shared types and constants of the argmax selector with hysteresis and hold time.
package ashd_pkg;

   localparam int VALUE_W    = 24;
   localparam int MARGIN_W   = 23;
   localparam int DWELL_W    = 16;
   localparam int WLEN_W     = 5;
   localparam int IDX_W      = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 23;

   localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd200;
   localparam logic [DWELL_W-1:0] TICK_MAX    = 16'hFFFF;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DWELL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd2;

   // Result queue.
   localparam int OUT_DEPTH = 8;
   localparam int OUT_PTR_W = 3;
   localparam int OUT_CNT_W = 4;

   typedef enum logic [1:0] {
      OP_FRAME   = 2'd0,
      OP_TICK    = 2'd1,
      OP_REISSUE = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } stage_type;

endpackage

@@ design/ashd_ram.sv @@
// Generic single-write, registered-read RAM with read-first behavior.
module ashd_ram #(
   parameter int WIDTH  = 24,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/ashd_lane.sv @@
// One channel lane: history ring in RAM and the running sum of the window.
module ashd_lane #(
   parameter int MAX_WINDOW = 16,
   parameter int ADDR_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
   parameter int SUM_W      = ashd_pkg::VALUE_W + $clog2(MAX_WINDOW)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [ADDR_W-1:0]                   addr,
   input  logic signed [ashd_pkg::VALUE_W-1:0] value_i,
   input  logic                                upd,
   input  logic                                full,
   input  logic                                clr,
   output logic signed [SUM_W-1:0]             sum_o
);
   import ashd_pkg::*;

   logic [VALUE_W-1:0]        old_value;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [SUM_W-1:0]   sub_value;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   sum_in;

   // The old entry is read and the new one written in the same cycle.
   ashd_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_WINDOW),
      .ADDR_W(ADDR_W)
   ) u_hist (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(addr),
      .wr_data(value_i),
      .rd_en  (wr_en),
      .rd_addr(addr),
      .rd_data(old_value)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_ff <= value_i;
      end
   end

   always_comb begin
      sub_value = full ? SUM_W'($signed(old_value)) : '0;
      sum_in    = sum_ff;
      if (clr) begin
         sum_in = '0;
      end else if (upd) begin
         sum_in = sum_ff - sub_value + SUM_W'(value_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign sum_o = sum_ff;

endmodule

@@ design/ashd_merge.sv @@
// Merging stage: argmax tree over the lane sums, sum snapshot and margin product.
module ashd_merge #(
   parameter int NUM_INPUTS = 4,
   parameter int SUM_W      = 28,
   parameter int FILL_W     = 5,
   parameter int CH_W       = $clog2(NUM_INPUTS),
   parameter int NEED_W     = ashd_pkg::MARGIN_W + FILL_W
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ashd_pkg::stage_type                  s2_i,
   input  logic [FILL_W-1:0]                    fill_i,
   input  logic [ashd_pkg::MARGIN_W-1:0]        margin_i,
   input  logic signed [SUM_W-1:0]              sum_i  [NUM_INPUTS],
   output ashd_pkg::stage_type                  s3_o,
   output logic [CH_W-1:0]                      cand_o,
   output logic signed [SUM_W-1:0]              snap_o [NUM_INPUTS],
   output logic [NEED_W-1:0]                    need_o
);
   import ashd_pkg::*;

   localparam int NUM_PAD = 1 << CH_W;

   logic                    node_ok  [2*NUM_PAD];
   logic [CH_W-1:0]         node_idx [2*NUM_PAD];
   logic signed [SUM_W-1:0] node_sum [2*NUM_PAD];
   logic                    take_right;

   stage_type               s3_ff;
   logic [CH_W-1:0]         cand_ff;
   logic signed [SUM_W-1:0] snap_ff [NUM_INPUTS];
   logic [NEED_W-1:0]       need_ff;

   // Heap-ordered tree: the left child always holds the lower channels, so the
   // right one wins only when it is strictly larger, which keeps the lowest
   // index on a tie.
   always_comb begin
      take_right = 1'b0;
      for (int n = 0; n < 2*NUM_PAD; n++) begin
         node_ok[n]  = 1'b0;
         node_idx[n] = '0;
         node_sum[n] = '0;
      end
      for (int c = 0; c < NUM_PAD; c++) begin
         node_idx[NUM_PAD+c] = CH_W'(c);
      end
      for (int c = 0; c < NUM_INPUTS; c++) begin
         node_ok[NUM_PAD+c]  = 1'b1;
         node_sum[NUM_PAD+c] = sum_i[c];
      end
      for (int n = NUM_PAD-1; n >= 1; n--) begin
         take_right = node_ok[2*n+1] &&
                      (!node_ok[2*n] || (node_sum[2*n+1] > node_sum[2*n]));
         node_ok[n]  = take_right ? node_ok[2*n+1]  : node_ok[2*n];
         node_idx[n] = take_right ? node_idx[2*n+1] : node_idx[2*n];
         node_sum[n] = take_right ? node_sum[2*n+1] : node_sum[2*n];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff <= '0;
      end else begin
         s3_ff <= s2_i;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= node_idx[1];
      snap_ff <= sum_i;
      need_ff <= NEED_W'(margin_i) * NEED_W'(fill_i);
   end

   assign s3_o   = s3_ff;
   assign cand_o = cand_ff;
   assign snap_o = snap_ff;
   assign need_o = need_ff;

endmodule

@@ design/ashd_decide.sv @@
// Winner state: first pick, hysteresis and hold-time test, ticks, reissue and clear.
module ashd_decide #(
   parameter int NUM_INPUTS = 4,
   parameter int SUM_W      = 28,
   parameter int NEED_W     = 28,
   parameter int CH_W       = $clog2(NUM_INPUTS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ashd_pkg::stage_type               s3_i,
   input  logic [CH_W-1:0]                   cand_i,
   input  logic signed [SUM_W-1:0]           snap_i [NUM_INPUTS],
   input  logic [NEED_W-1:0]                 need_i,
   input  logic [ashd_pkg::DWELL_W-1:0]      dwell_i,
   output logic                              push_o,
   output logic [ashd_pkg::IDX_W-1:0]        index_o
);
   import ashd_pkg::*;

   localparam int CMP_W = ((SUM_W + 1) > (NEED_W + 1)) ? (SUM_W + 1) : (NEED_W + 1);

   logic [CH_W-1:0]         winner_ff;
   logic [CH_W-1:0]         winner_in;
   logic                    winner_valid_ff;
   logic                    winner_valid_in;
   logic [DWELL_W-1:0]      elapsed_ff;
   logic [DWELL_W-1:0]      elapsed_in;
   logic signed [SUM_W:0]   diff;
   logic signed [CMP_W-1:0] diff_x;
   logic signed [CMP_W-1:0] need_x;
   logic                    switch_ok;

   always_comb begin
      diff      = (SUM_W+1)'(snap_i[cand_i]) - (SUM_W+1)'(snap_i[winner_ff]);
      diff_x    = CMP_W'(diff);
      need_x    = CMP_W'($signed({1'b0, need_i}));
      switch_ok = (cand_i != winner_ff) && (diff_x >= need_x) && (elapsed_ff >= dwell_i);
   end

   always_comb begin
      winner_in       = winner_ff;
      winner_valid_in = winner_valid_ff;
      elapsed_in      = elapsed_ff;
      push_o          = 1'b0;
      if (s3_i.valid) begin
         case (s3_i.op)
            OP_FRAME: begin
               if (!winner_valid_ff || switch_ok) begin
                  winner_in       = cand_i;
                  winner_valid_in = 1'b1;
                  elapsed_in      = '0;
                  push_o          = 1'b1;
               end
            end
            OP_TICK: begin
               if (elapsed_ff != TICK_MAX) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
            end
            OP_REISSUE: begin
               push_o = winner_valid_ff;
            end
            OP_CLEAR: begin
               winner_valid_in = 1'b0;
               elapsed_in      = '0;
            end
            default: begin
               push_o = 1'b0;
            end
         endcase
      end
      index_o = IDX_W'(winner_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         winner_ff       <= '0;
         winner_valid_ff <= 1'b0;
         elapsed_ff      <= '0;
      end else begin
         winner_ff       <= winner_in;
         winner_valid_ff <= winner_valid_in;
         elapsed_ff      <= elapsed_in;
      end
   end

endmodule

@@ design/argmax_selector_hysteresis_dwell.sv @@
// A result goes from its item through the lanes, merge and decide into the result queue.
// Throughput: one item per cycle; the limit is the single write/read port of each history RAM.
// Items in flight plus queued results are held to eight, so ready drops only under output stall.
// Reset is synchronous and active high: registers take their reset values, sums clear at once.
// History RAMs are not cleared; an old entry is only used after it was written.
// A change of the effective window length restarts the history in the same cycle.
module argmax_selector_hysteresis_dwell #(
   parameter int NUM_INPUTS = 4,
   parameter int MAX_WINDOW = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_op,
   input  logic signed [ashd_pkg::VALUE_W-1:0]  req_value_0,
   input  logic signed [ashd_pkg::VALUE_W-1:0]  req_value_1,
   input  logic signed [ashd_pkg::VALUE_W-1:0]  req_value_2,
   input  logic signed [ashd_pkg::VALUE_W-1:0]  req_value_3,
   input  logic signed [ashd_pkg::VALUE_W-1:0]  req_value_4,
   input  logic signed [ashd_pkg::VALUE_W-1:0]  req_value_5,
   input  logic signed [ashd_pkg::VALUE_W-1:0]  req_value_6,
   input  logic signed [ashd_pkg::VALUE_W-1:0]  req_value_7,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ashd_pkg::IDX_W-1:0]           rsp_winner_index,
   input  logic                                 csr_wr_en,
   input  logic [ashd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ashd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ashd_pkg::*;

   localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int FILL_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = VALUE_W + $clog2(MAX_WINDOW);
   localparam int CH_W   = $clog2(NUM_INPUTS);
   localparam int NEED_W = MARGIN_W + FILL_W;
   localparam int NUM_PORTS = 8;

   // Configuration registers.
   logic [MARGIN_W-1:0] margin_ff;
   logic [DWELL_W-1:0]  dwell_ff;
   logic [FILL_W-1:0]   win_len_ff;
   logic [WLEN_W-1:0]   win_cfg;
   logic [FILL_W-1:0]   win_eff;
   logic                cfg_restart;

   // Window bookkeeping, shared by all lanes.
   logic [ADDR_W-1:0]   pos_ff;
   logic [ADDR_W-1:0]   pos_in;
   logic [FILL_W-1:0]   pos_inc;
   logic [FILL_W-1:0]   fill_ff;
   logic [FILL_W-1:0]   fill_in;
   logic                full;

   // Handshake and pipeline control.
   logic                accept;
   logic                frame_acc;
   logic                clear_acc;
   op_type              req_kind;
   stage_type           s1_ff;
   logic                s1_full_ff;
   logic [FILL_W-1:0]   s1_fill_ff;
   stage_type           s2_ff;
   logic [FILL_W-1:0]   s2_fill_ff;
   stage_type           s3;
   logic                lane_upd;
   logic                lane_clr;

   logic signed [VALUE_W-1:0] value_all [NUM_PORTS];
   logic signed [SUM_W-1:0]   lane_sum  [NUM_INPUTS];
   logic [CH_W-1:0]           cand;
   logic signed [SUM_W-1:0]   snap      [NUM_INPUTS];
   logic [NEED_W-1:0]         need;

   // Result queue.
   logic                 push;
   logic                 pop;
   logic [IDX_W-1:0]     push_index;
   logic [IDX_W-1:0]     queue_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] head_ff;
   logic [OUT_PTR_W-1:0] tail_ff;
   logic [OUT_CNT_W-1:0] count_ff;
   logic [OUT_CNT_W-1:0] count_in;
   logic [OUT_CNT_W-1:0] occupancy;

   // ------------------------------------------------------------------
   // Configuration. A window write is clamped to 1..MAX_WINDOW and only
   // restarts the history when the effective length actually changes.
   // ------------------------------------------------------------------
   always_comb begin
      win_cfg = csr_wdata[WLEN_W-1:0];
      if (win_cfg == '0) begin
         win_eff = FILL_W'(1);
      end else if (int'(win_cfg) > MAX_WINDOW) begin
         win_eff = FILL_W'(MAX_WINDOW);
      end else begin
         win_eff = FILL_W'(win_cfg);
      end
      cfg_restart = csr_wr_en && (csr_index == CSR_WINDOW) && (win_eff != win_len_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff  <= '0;
         dwell_ff   <= DWELL_RESET;
         win_len_ff <= FILL_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MARGIN: margin_ff  <= csr_wdata[MARGIN_W-1:0];
            CSR_DWELL:  dwell_ff   <= csr_wdata[DWELL_W-1:0];
            CSR_WINDOW: win_len_ff <= win_eff;
            default:    margin_ff  <= margin_ff;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Input side. Every item kind travels down the same pipeline so that
   // ticks, reissues and clears act on the winner in arrival order.
   // ------------------------------------------------------------------
   assign occupancy = count_ff + OUT_CNT_W'(s1_ff.valid) + OUT_CNT_W'(s2_ff.valid) +
                      OUT_CNT_W'(s3.valid);
   assign req_ready = occupancy < OUT_CNT_W'(OUT_DEPTH);
   assign accept    = req_valid && req_ready;
   assign req_kind  = op_type'(req_op);
   assign frame_acc = accept && (req_kind == OP_FRAME);
   assign clear_acc = accept && (req_kind == OP_CLEAR);

   // The ring position wraps at the window length; the fill count stops there.
   always_comb begin
      full    = fill_ff >= win_len_ff;
      pos_inc = FILL_W'(pos_ff) + FILL_W'(1);
      pos_in  = pos_ff;
      fill_in = fill_ff;
      if (cfg_restart || clear_acc) begin
         pos_in  = '0;
         fill_in = '0;
      end else if (frame_acc) begin
         pos_in = (pos_inc == win_len_ff) ? '0 : pos_inc[ADDR_W-1:0];
         if (!full) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         fill_ff <= '0;
         s1_ff   <= '0;
         s2_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         fill_ff  <= fill_in;
         s1_ff    <= '{valid: accept, op: req_kind};
         s2_ff    <= s1_ff;
      end
   end

   // The fill count that travels with a frame is the one after its update.
   always_ff @(posedge clock) begin
      s1_full_ff <= full;
      s1_fill_ff <= fill_in;
      s2_fill_ff <= s1_fill_ff;
   end

   // ------------------------------------------------------------------
   // Lanes. Each keeps its own history RAM and running sum; a lane sees
   // its old entry in the cycle after the frame's accept and folds it in.
   // ------------------------------------------------------------------
   assign value_all[0] = req_value_0;
   assign value_all[1] = req_value_1;
   assign value_all[2] = req_value_2;
   assign value_all[3] = req_value_3;
   assign value_all[4] = req_value_4;
   assign value_all[5] = req_value_5;
   assign value_all[6] = req_value_6;
   assign value_all[7] = req_value_7;

   assign lane_upd = s1_ff.valid && (s1_ff.op == OP_FRAME);
   assign lane_clr = (s1_ff.valid && (s1_ff.op == OP_CLEAR)) || cfg_restart;

   for (genvar c = 0; c < NUM_INPUTS; c++) begin : g_lane
      ashd_lane #(
         .MAX_WINDOW(MAX_WINDOW),
         .ADDR_W    (ADDR_W),
         .SUM_W     (SUM_W)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .wr_en  (frame_acc),
         .addr   (pos_ff),
         .value_i(value_all[c]),
         .upd    (lane_upd),
         .full   (s1_full_ff),
         .clr    (lane_clr),
         .sum_o  (lane_sum[c])
      );
   end

   // ------------------------------------------------------------------
   // Merge the lanes into a candidate, then decide on the winner.
   // ------------------------------------------------------------------
   ashd_merge #(
      .NUM_INPUTS(NUM_INPUTS),
      .SUM_W     (SUM_W),
      .FILL_W    (FILL_W),
      .CH_W      (CH_W),
      .NEED_W    (NEED_W)
   ) u_merge (
      .clock   (clock),
      .reset   (reset),
      .s2_i    (s2_ff),
      .fill_i  (s2_fill_ff),
      .margin_i(margin_ff),
      .sum_i   (lane_sum),
      .s3_o    (s3),
      .cand_o  (cand),
      .snap_o  (snap),
      .need_o  (need)
   );

   ashd_decide #(
      .NUM_INPUTS(NUM_INPUTS),
      .SUM_W     (SUM_W),
      .NEED_W    (NEED_W),
      .CH_W      (CH_W)
   ) u_decide (
      .clock  (clock),
      .reset  (reset),
      .s3_i   (s3),
      .cand_i (cand),
      .snap_i (snap),
      .need_i (need),
      .dwell_i(dwell_ff),
      .push_o (push),
      .index_o(push_index)
   );

   // ------------------------------------------------------------------
   // Result queue. The credit check on req_ready guarantees a free slot
   // for every item still in the pipeline.
   // ------------------------------------------------------------------
   assign pop              = rsp_valid && rsp_ready;
   assign rsp_valid        = count_ff != '0;
   assign rsp_winner_index = queue_ff[head_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + OUT_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            tail_ff <= tail_ff + OUT_PTR_W'(1);
         end
         if (pop) begin
            head_ff <= head_ff + OUT_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[tail_ff] <= push_index;
      end
   end

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= OUT_CNT_W'(OUT_DEPTH))
      else $error("result queue holds more items than it has slots");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != OUT_CNT_W'(OUT_DEPTH)) || pop)
      else $error("result pushed into a full queue");

   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      push |-> s3.valid && ((s3.op == OP_FRAME) || (s3.op == OP_REISSUE)))
      else $error("result produced by a tick or clear item");

   a_pos_in_window: assert property (@(posedge clock) disable iff (reset)
      (FILL_W'(pos_ff) < win_len_ff) && (fill_ff <= win_len_ff))
      else $error("ring position or fill count outside the window");
`endif

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the argmax selector with hysteresis and dwell time.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ashd_pkg::*;

   // The block is built with four live channels and a sixteen-frame window.
   localparam int NUM_CH       = 4;
   localparam int MAX_WIN      = 16;
   // Cycles of quiet after the last expected result before a register write or the end.
   // This leaves ample room for the block to answer the last item.
   localparam int DRAIN_CYCLES = 12;
   // The limit lies well above the slowest correct run.
   localparam int CYCLE_LIMIT  = 60000;
   // Register index that the block does not decode; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   // One input item: its kind and all eight channel values as they appear on the ports.
   typedef struct packed {
      op_type                  op;
      logic [7:0][VALUE_W-1:0] value;
   } selector_item_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_op;
   logic [7:0][VALUE_W-1:0] req_value;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [IDX_W-1:0]      rsp_winner_index;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Items waiting to be driven, and winner indexes the block still owes us.
   selector_item_type item_queue[$];
   logic [IDX_W-1:0]  expected_winners[$];
   selector_item_type driven_item;

   // Idle percentages of the sender and the receiver, set per phase.
   int req_idle_pct;
   int rsp_idle_pct;

   // Our own copy of the selector state and its registers.
   logic [MARGIN_W-1:0]       margin_q;
   logic [DWELL_W-1:0]        dwell_min;
   logic [WLEN_W-1:0]         window_len;
   logic signed [VALUE_W-1:0] ring [NUM_CH][MAX_WIN];
   logic signed [27:0]        chan_sum [NUM_CH];
   logic [3:0]                wr_pos;
   logic [4:0]                fill_level;
   logic [IDX_W-1:0]          cur_winner;
   bit                        have_winner;
   logic [DWELL_W-1:0]        ticks_elapsed;

   int frame_leader;
   int cycle_count;
   int mismatch_count;
   int items_accepted;
   int results_checked;
   int winner_switches;
   int csr_writes;
   int window_plan [9] = '{1, 4, 16, 0, 3, 25, 8, 2, 16};

   argmax_selector_hysteresis_dwell #(
      .NUM_INPUTS(NUM_CH),
      .MAX_WINDOW(MAX_WIN)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_value_0     (req_value[0]),
      .req_value_1     (req_value[1]),
      .req_value_2     (req_value[2]),
      .req_value_3     (req_value[3]),
      .req_value_4     (req_value[4]),
      .req_value_5     (req_value[5]),
      .req_value_6     (req_value[6]),
      .req_value_7     (req_value[7]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_winner_index(rsp_winner_index),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Every mismatch goes through here: one line, one count. Printing stops after
   // twenty lines so that a badly broken block cannot flood the log.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 20) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
   endtask

   // Clearing and any change of the effective window length empty the history.
   task automatic restart_windows();
      wr_pos     = '0;
      fill_level = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         chan_sum[c] = '0;
      end
   endtask

   // Predicts what one accepted item does to the selector, and queues the winner
   // index that the block has to emit for it, if any.
   task automatic predict_winner(input selector_item_type it);
      logic signed [VALUE_W-1:0] v;
      logic [IDX_W-1:0]          cand;
      bit                        full;
      longint                    diff;
      longint                    need;
      case (it.op)
         OP_TICK: begin
            if (ticks_elapsed != TICK_MAX) begin
               ticks_elapsed++;
            end
         end
         OP_REISSUE: begin
            if (have_winner) begin
               expected_winners.push_back(cur_winner);
            end
         end
         OP_CLEAR: begin
            have_winner   = 1'b0;
            ticks_elapsed = '0;
            restart_windows();
         end
         default: begin
            // Once the window is full, the oldest frame leaves the sums as the new one enters.
            full = (fill_level >= window_len);
            for (int c = 0; c < NUM_CH; c++) begin
               v = it.value[c];
               if (full) begin
                  chan_sum[c] = chan_sum[c] - ring[c][wr_pos];
               end
               ring[c][wr_pos] = v;
               chan_sum[c]     = chan_sum[c] + v;
            end
            wr_pos = 4'((int'(wr_pos) + 1) % int'(window_len));
            if (!full) begin
               fill_level++;
            end
            // All channels share one fill level, so the largest sum is the largest average.
            cand = '0;
            for (int c = 1; c < NUM_CH; c++) begin
               if (chan_sum[c] > chan_sum[cand]) begin
                  cand = IDX_W'(c);
               end
            end
            if (!have_winner) begin
               cur_winner    = cand;
               have_winner   = 1'b1;
               ticks_elapsed = '0;
               expected_winners.push_back(cur_winner);
            end else if (cand != cur_winner) begin
               // The margin applies to averages, so on sums it scales with the fill level.
               diff = longint'(chan_sum[cand]) - longint'(chan_sum[cur_winner]);
               need = longint'(margin_q) * longint'(fill_level);
               if (diff >= need && ticks_elapsed >= dwell_min) begin
                  cur_winner    = cand;
                  ticks_elapsed = '0;
                  winner_switches++;
                  expected_winners.push_back(cur_winner);
               end
            end
         end
      endcase
   endtask

   // Writes one register and applies the same write to our copy. Only called
   // while the block is idle, so no item can overlap the write.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      logic [WLEN_W-1:0] w;
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_MARGIN: margin_q = data[MARGIN_W-1:0];
         CSR_DWELL:  dwell_min = data[DWELL_W-1:0];
         CSR_WINDOW: begin
            // Zero acts as one and anything above the ring depth as the full depth.
            w = data[WLEN_W-1:0];
            if (w < 1) begin
               w = WLEN_W'(1);
            end
            if (w > MAX_WIN) begin
               w = WLEN_W'(MAX_WIN);
            end
            if (w != window_len) begin
               window_len = w;
               restart_windows();
            end
         end
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
      csr_writes++;
   endtask

   // Waits at falling edges until every item is accepted and every result has
   // come back, then lets the pipeline settle before it returns.
   task automatic wait_until_idle();
      do begin
         @(negedge clock);
      end while (item_queue.size() != 0 || req_valid || expected_winners.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // A non-frame item, or the start of a frame, with every value lane random.
   function automatic selector_item_type op_item(input op_type op);
      selector_item_type it;
      it.op = op;
      for (int c = 0; c < 8; c++) begin
         it.value[c] = VALUE_W'($urandom);
      end
      return it;
   endfunction

   function automatic selector_item_type make_frame(input logic signed [VALUE_W-1:0] v0,
                                                    input logic signed [VALUE_W-1:0] v1,
                                                    input logic signed [VALUE_W-1:0] v2,
                                                    input logic signed [VALUE_W-1:0] v3);
      selector_item_type it;
      it          = op_item(OP_FRAME);
      it.value[0] = v0;
      it.value[1] = v1;
      it.value[2] = v2;
      it.value[3] = v3;
      return it;
   endfunction

   // Most frames favor one leading channel that changes now and then, so that
   // averages drift and the hysteresis and dwell paths are really exercised.
   // A few frames are all-equal ties, and some carry full-range values.
   function automatic selector_item_type random_frame();
      selector_item_type it;
      int shape;
      int b;
      int n;
      it    = op_item(OP_FRAME);
      shape = $urandom_range(9);
      if ($urandom_range(99) < 15) begin
         frame_leader = $urandom_range(NUM_CH - 1);
      end
      if (shape == 0) begin
         b = $urandom;
         for (int c = 0; c < NUM_CH; c++) begin
            it.value[c] = VALUE_W'(b);
         end
      end else if (shape < 8) begin
         b = int'($urandom_range(0, 1 << 21)) - (1 << 20);
         for (int c = 0; c < NUM_CH; c++) begin
            n = int'($urandom_range(0, 1 << 16)) - (1 << 15);
            if (c == frame_leader) begin
               n += int'($urandom_range(0, 1 << 19));
            end
            it.value[c] = VALUE_W'(b + n);
         end
      end
      return it;
   endfunction

   function automatic selector_item_type random_item();
      int r;
      r = $urandom_range(99);
      if (r < 48) begin
         return random_frame();
      end else if (r < 82) begin
         return op_item(OP_TICK);
      end else if (r < 96) begin
         return op_item(OP_REISSUE);
      end
      return op_item(OP_CLEAR);
   endfunction

   // Driver: offers the next queued item whenever the channel is free, and runs
   // the prediction for every item at the edge where it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_winner(driven_item);
            items_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (item_queue.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               driven_item = item_queue.pop_front();
               req_valid  <= 1'b1;
               req_op     <= driven_item.op;
               req_value  <= driven_item.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result against the oldest expectation and
   // stalls the result channel at random.
   always @(posedge clock) begin
      logic [IDX_W-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_winners.size() == 0) begin
               report_mismatch($sformatf("winner %0d emitted with no result expected",
                                         rsp_winner_index));
            end else begin
               want = expected_winners.pop_front();
               results_checked++;
               if (rsp_winner_index !== want) begin
                  report_mismatch($sformatf("winner_index %0d, expected %0d",
                                            rsp_winner_index, want));
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, expected_winners.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] margin_pick;
      logic [CSR_DATA_W-1:0] dwell_pick;
      int                    r;

      // Every input is known from time zero.
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op       = OP_FRAME;
      req_value    = '0;
      rsp_ready    = 1'b0;
      csr_wr_en    = 1'b0;
      csr_index    = CSR_MARGIN;
      csr_wdata    = '0;
      req_idle_pct = 29;
      rsp_idle_pct = 66;
      frame_leader = 0;

      // Our copy starts from the reset values of the block.
      margin_q      = '0;
      dwell_min     = DWELL_RESET;
      window_len    = WLEN_W'(1);
      have_winner   = 1'b0;
      cur_winner    = '0;
      ticks_elapsed = '0;
      restart_windows();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, first at the reset settings: margin zero, dwell 200, window one.
      // A reissue before any frame has no winner to repeat, and the first frame
      // picks freely. The all-equal frame is a tie won by channel zero, but the
      // dwell time keeps channel two. After a clear there is again no winner.
      item_queue.push_back(op_item(OP_REISSUE));
      item_queue.push_back(op_item(OP_TICK));
      item_queue.push_back(make_frame(VALUE_MIN, '0, VALUE_MAX, VALUE_W'(-1)));
      item_queue.push_back(make_frame(VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX));
      item_queue.push_back(op_item(OP_REISSUE));
      item_queue.push_back(op_item(OP_CLEAR));
      item_queue.push_back(op_item(OP_REISSUE));
      item_queue.push_back(make_frame(VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MIN));
      wait_until_idle();

      // No dwell and a margin of one LSB: a lead of exactly one switches, a tie does
      // not. A window of zero acts as one, which is no change. The unused index
      // must be ignored.
      write_csr(CSR_DWELL, '0);
      write_csr(CSR_MARGIN, CSR_DATA_W'(1));
      write_csr(CSR_WINDOW, '0);
      write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
      @(negedge clock);
      item_queue.push_back(make_frame(VALUE_W'(5), VALUE_W'(6), '0, '0));
      item_queue.push_back(make_frame(VALUE_W'(6), VALUE_W'(6), '0, '0));
      item_queue.push_back(make_frame('0, '0, '0, VALUE_W'(9)));
      wait_until_idle();

      // Window above the ring depth acts as sixteen and restarts the history while
      // the winner is kept. With the largest margin a full-scale lead is still
      // enough, but only after two ticks of dwell.
      write_csr(CSR_WINDOW, CSR_DATA_W'(20));
      write_csr(CSR_MARGIN, {CSR_DATA_W{1'b1}});
      write_csr(CSR_DWELL, CSR_DATA_W'(2));
      @(negedge clock);
      item_queue.push_back(make_frame(VALUE_MAX, VALUE_MIN, VALUE_MIN, VALUE_MIN));
      item_queue.push_back(op_item(OP_TICK));
      item_queue.push_back(op_item(OP_TICK));
      item_queue.push_back(make_frame(VALUE_MAX, VALUE_MIN, VALUE_MIN, VALUE_MIN));
      item_queue.push_back(op_item(OP_REISSUE));
      wait_until_idle();

      // Window of two so that old frames leave the sums; the dwell write carries
      // junk in the bits above the register.
      write_csr(CSR_WINDOW, CSR_DATA_W'(2));
      write_csr(CSR_MARGIN, '0);
      write_csr(CSR_DWELL, 23'h7F0001);
      @(negedge clock);
      item_queue.push_back(make_frame('0, VALUE_MAX, '0, '0));
      item_queue.push_back(op_item(OP_TICK));
      item_queue.push_back(make_frame('0, '0, VALUE_MAX, '0));
      item_queue.push_back(op_item(OP_TICK));
      item_queue.push_back(make_frame('0, '0, '0, VALUE_MAX));
      item_queue.push_back(make_frame(VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MIN));
      item_queue.push_back(op_item(OP_REISSUE));
      wait_until_idle();

      // Random part: nine phases, each with its own window, margin and dwell.
      // The first three stall mostly the receiver, the next three mostly the
      // sender, the last three run at full rate.
      for (int p = 0; p < 9; p++) begin
         r = $urandom_range(3);
         if (p == 5) begin
            margin_pick = {CSR_DATA_W{1'b1}};
         end else if (r == 0) begin
            margin_pick = '0;
         end else begin
            margin_pick = CSR_DATA_W'($urandom_range(0, 1 << (8 + 4 * r)));
         end
         if ($urandom_range(3) == 0) begin
            dwell_pick = CSR_DATA_W'($urandom_range(0, 40));
         end else begin
            dwell_pick = CSR_DATA_W'($urandom_range(0, 4));
         end
         write_csr(CSR_WINDOW, CSR_DATA_W'(window_plan[p]));
         write_csr(CSR_MARGIN, margin_pick);
         write_csr(CSR_DWELL, dwell_pick);
         @(negedge clock);
         if (p < 3) begin
            req_idle_pct = 29;
            rsp_idle_pct = 66;
         end else if (p < 6) begin
            req_idle_pct = 66;
            rsp_idle_pct = 29;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         repeat (140) item_queue.push_back(random_item());
         wait_until_idle();
      end

      $display("run covered %0d items over %0d register writes, with %0d winner switches",
               items_accepted, csr_writes, winner_switches);
      $display("%0d winner results checked, %0d mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
